// File: rtl/hjd_pkg.sv
// Shared types and constants for the headset jack detect block.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package hjd_pkg;

    // Upper bound on the number of polarity/bias modes that are tried
    localparam int HJD_MAX_MODES = 8;
    localparam int HJD_MODE_CAP  = (HJD_MAX_MODES < 8) ? HJD_MAX_MODES : 8;
    localparam logic [3:0] MODE_LIMIT = 4'(HJD_MODE_CAP);

    localparam logic [3:0] MODE_COUNT_RST = 4'd2;
    localparam logic [3:0] FLIP_MAX       = 4'd15;

    // Event kinds
    localparam logic ACT_JACK = 1'b0;
    localparam logic ACT_MIC  = 1'b1;

    // Impedance field layout
    localparam int IMP_HIGH_BIT = 8;

    // Accessory codes
    localparam logic [1:0] ACC_NONE       = 2'd0;
    localparam logic [1:0] ACC_HEADSET    = 2'd1;
    localparam logic [1:0] ACC_HEADPHONES = 2'd2;

    typedef struct packed {
        logic       action;
        logic       jack_present;
        logic       detect_valid;
        logic       detect_closed;
        logic [8:0] impedance_level;
    } t_item;

    typedef struct packed {
        logic       event_handled;
        logic       report_valid;
        logic [1:0] accessory_state;
        logic [2:0] polarity_mode;
        logic       detect_enable;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/hjd_in_stage.sv
// Input register for the headset jack detect block.
// Depends on hjd_pkg for the request type.
`default_nettype none

module hjd_in_stage import hjd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    // Held request blocks new ones only while the result side is full
    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/hjd_core.sv
// Detection state and per-request decision logic.
// Holds the mode count register and the detect flags; depends on hjd_pkg.
`default_nettype none

module hjd_core import hjd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       i_fire,
    input  wire t_item      i_item,
    output t_result         o_result
);

    logic [3:0] r_mode_count;
    logic       r_detecting, n_detecting;
    logic       r_mic_found, n_mic_found;
    logic [3:0] r_flip_count, n_flip_count;
    logic [2:0] r_mode_index, n_mode_index;
    logic       r_detect_on, n_detect_on;

    logic       handled;
    logic       report;
    logic [1:0] acc;
    logic [3:0] n_modes;
    logic [3:0] flip_inc;
    logic [2:0] mode_step;
    logic       imp_high;
    logic       imp_mid;
    logic       imp_short;

    always_comb begin
        if (r_mode_count == 4'd0) begin
            n_modes = 4'd1;
        end else if (r_mode_count > MODE_LIMIT) begin
            n_modes = MODE_LIMIT;
        end else begin
            n_modes = r_mode_count;
        end
    end

    assign imp_high  = i_item.impedance_level[IMP_HIGH_BIT];
    assign imp_mid   = |i_item.impedance_level[7:1];
    assign imp_short = |i_item.impedance_level[7:0];
    assign flip_inc  = (r_flip_count == FLIP_MAX) ? r_flip_count : r_flip_count + 4'd1;
    assign mode_step = r_mode_index + 3'd1;

    always_comb begin
        n_detecting  = r_detecting;
        n_mic_found  = r_mic_found;
        n_flip_count = r_flip_count;
        n_mode_index = r_mode_index;
        n_detect_on  = r_detect_on;
        handled      = 1'b1;
        report       = 1'b0;
        acc          = ACC_NONE;

        if (i_item.action == ACT_JACK) begin
            if (i_item.jack_present) begin
                n_detecting  = 1'b1;
                n_mic_found  = 1'b0;
                n_flip_count = 4'd0;
                n_detect_on  = 1'b1;
            end else begin
                n_detect_on = 1'b0;
                report      = 1'b1;
            end
        end else if (!i_item.detect_valid) begin
            handled = 1'b0;
        end else if (!i_item.detect_closed) begin
            n_detecting = 1'b0;
        end else if (r_detecting && imp_high) begin
            report      = 1'b1;
            acc         = ACC_HEADSET;
            n_mic_found = 1'b1;
            n_detecting = 1'b0;
        end else if (r_detecting && imp_mid) begin
            n_flip_count = flip_inc;
            if (flip_inc >= n_modes) begin
                // every mode tried: no mic
                n_detecting = 1'b0;
                report      = 1'b1;
                acc         = ACC_HEADPHONES;
            end else if ({1'b0, mode_step} >= n_modes) begin
                n_mode_index = 3'd0;
            end else begin
                n_mode_index = mode_step;
            end
        end else if (imp_short) begin
            // with a mic present, or after detection, a short is button activity
            if (!r_mic_found && r_detecting) begin
                n_detecting = 1'b0;
                n_detect_on = 1'b0;
                report      = 1'b1;
                acc         = ACC_HEADPHONES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count <= MODE_COUNT_RST;
            r_detecting  <= 1'b1;
            r_mic_found  <= 1'b0;
            r_flip_count <= 4'd0;
            r_mode_index <= 3'd0;
            r_detect_on  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode_count <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_detecting  <= n_detecting;
                r_mic_found  <= n_mic_found;
                r_flip_count <= n_flip_count;
                r_mode_index <= n_mode_index;
                r_detect_on  <= n_detect_on;
            end
        end
    end

    assign o_result.event_handled   = handled;
    assign o_result.report_valid    = report;
    assign o_result.accessory_state = acc;
    assign o_result.polarity_mode   = n_mode_index;
    assign o_result.detect_enable   = n_detect_on;

    a_insert_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_JACK && i_item.jack_present
        |=> r_detect_on && r_detecting && r_flip_count == 4'd0)
        else $error("insertion did not arm detection");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_flip_count) && $stable(r_mode_index) && $stable(r_detect_on))
        else $error("detect state moved without a request");

    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_MIC && !i_item.detect_valid
        |=> $stable(r_detecting) && $stable(r_mic_found) && $stable(r_flip_count))
        else $error("invalid reading changed detect state");

    a_flip_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_MIC |=> r_flip_count >= $past(r_flip_count))
        else $error("flip count went backwards on a mic reading");

endmodule

`default_nettype wire

// File: rtl/hjd_out_stage.sv
// Result register for the headset jack detect block.
// Depends on hjd_pkg for the result type.
`default_nettype none

module hjd_out_stage import hjd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_advance,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Register is free when empty or being drained this cycle
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_no_report_on_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_result.event_handled |-> !r_result.report_valid)
        else $error("ignored request carries a report");

    a_quiet_state_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_result.report_valid |-> r_result.accessory_state == ACC_NONE)
        else $error("accessory code without a report");

endmodule

`default_nettype wire

// File: rtl/headset_jack_detect_fsm_unit.sv
// Headset jack detect state machine, top level.
// Instantiates hjd_in_stage, hjd_core and hjd_out_stage; depends on hjd_pkg.
//
// Requests: one event per request on i_valid / o_stall, either a jack
// event (insert/remove) or a mic-detect reading with its impedance bits.
// Results: one result per request on o_valid / i_stall, carrying whether
// the event was handled, an optional accessory report, the polarity mode
// for the analog front end and the detect enable.
// Config: i_cfg_we writes the number of polarity modes to try (4 bits).
// Path: a request goes through the input register, then the result
// register, to o_valid. Throughput: one request per cycle while i_stall
// is low; the whole decision is a single pass through the flag and
// counter logic between the two registers.
// Reset (i_rst_n low at a clock edge): both registers empty, detect flags
// back to detecting/no mic/disabled, mode count back to 2.
// Stall: a stalled result holds; one more request is held in the input
// register, after which o_stall rises until the result is taken.
`default_nettype none

module headset_jack_detect_fsm_unit import hjd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_action,
    input  wire logic       i_jack_present,
    input  wire logic       i_detect_valid,
    input  wire logic       i_detect_closed,
    input  wire logic [8:0] i_impedance_level,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_event_handled,
    output logic            o_report_valid,
    output logic [1:0]      o_accessory_state,
    output logic [2:0]      o_polarity_mode,
    output logic            o_detect_enable
);

    t_item   req_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    fire;
    t_result core_result;
    t_result out_result;

    assign req_item.action          = i_action;
    assign req_item.jack_present    = i_jack_present;
    assign req_item.detect_valid    = i_detect_valid;
    assign req_item.detect_closed   = i_detect_closed;
    assign req_item.impedance_level = i_impedance_level;

    hjd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (req_item),
        .i_advance (advance),
        .o_stall   (o_stall),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    assign fire = held_valid && advance;

    hjd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    hjd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_result  (core_result),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_result  (out_result)
    );

    assign o_event_handled   = out_result.event_handled;
    assign o_report_valid    = out_result.report_valid;
    assign o_accessory_state = out_result.accessory_state;
    assign o_polarity_mode   = out_result.polarity_mode;
    assign o_detect_enable   = out_result.detect_enable;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && held_valid)
        else $error("request side stalled with room downstream");

    a_taken_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("processed request produced no result");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !held_valid && o_valid && !i_stall |=> !o_valid)
        else $error("result appeared with nothing processed");

endmodule

`default_nettype wire

// File: tb/sv/tb_headset_jack_detect_fsm_unit.sv
// Self-checking testbench for headset_jack_detect_fsm_unit.
// Predicts each result from accepted requests and compares it field by field.
// Depends on rtl/hjd_pkg.sv and the block's RTL.
`default_nettype none

module tb_headset_jack_detect_fsm_unit import hjd_pkg::*; ;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int LONG_HOLD      = 40;
    localparam int PHASE_ITEMS    = 150;
    localparam int NUM_PHASES     = 10;
    localparam int ITEM_W         = $bits(t_item);

    // Tracks the detect flags, flip count and polarity mode; holds the
    // results owed for accepted requests, oldest first.
    class jack_event_scoreboard;
        logic [3:0] mode_count;
        bit         detecting;
        bit         mic_found;
        logic [3:0] flip_count;
        logic [2:0] mode_index;
        bit         detect_on;
        t_result    expected_results[$];
        int         errors;

        function new();
            mode_count = MODE_COUNT_RST;
            detecting  = 1'b1;
            mic_found  = 1'b0;
            flip_count = '0;
            mode_index = '0;
            detect_on  = 1'b0;
            errors     = 0;
        endfunction

        function void set_mode_count(logic [3:0] value);
            mode_count = value;
        endfunction

        function logic [3:0] modes_in_use();
            logic [3:0] n;
            n = mode_count;
            if (n == 0) n = 4'd1;
            if (n > MODE_LIMIT) n = MODE_LIMIT;
            return n;
        endfunction

        function void note_request(t_item it);
            t_result    r;
            logic [3:0] n;
            n = modes_in_use();
            r.event_handled   = 1'b1;
            r.report_valid    = 1'b0;
            r.accessory_state = ACC_NONE;
            if (it.action == ACT_JACK) begin
                if (it.jack_present) begin
                    detecting  = 1'b1;
                    mic_found  = 1'b0;
                    flip_count = '0;
                    detect_on  = 1'b1;
                end else begin
                    detect_on      = 1'b0;
                    r.report_valid = 1'b1;
                end
            end else if (!it.detect_valid) begin
                r.event_handled = 1'b0;
            end else if (!it.detect_closed) begin
                detecting = 1'b0;
            end else if (detecting && it.impedance_level[IMP_HIGH_BIT]) begin
                r.report_valid    = 1'b1;
                r.accessory_state = ACC_HEADSET;
                mic_found         = 1'b1;
                detecting         = 1'b0;
            end else if (detecting && it.impedance_level[7:1] != 0) begin
                if (flip_count != FLIP_MAX) flip_count++;
                if (flip_count >= n) begin
                    detecting         = 1'b0;
                    r.report_valid    = 1'b1;
                    r.accessory_state = ACC_HEADPHONES;
                end else begin
                    mode_index = mode_index + 3'd1;
                    // index left over from a larger count wraps here
                    if ({1'b0, mode_index} >= n) mode_index = '0;
                end
            end else if (it.impedance_level[7:0] != 0) begin
                // with a mic found or detection over this is button activity
                if (!mic_found && detecting) begin
                    detecting         = 1'b0;
                    detect_on         = 1'b0;
                    r.report_valid    = 1'b1;
                    r.accessory_state = ACC_HEADPHONES;
                end
            end
            r.polarity_mode = mode_index;
            r.detect_enable = detect_on;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("event_handled", 4'(want.event_handled),
                          4'(got.event_handled));
            compare_field("report_valid", 4'(want.report_valid),
                          4'(got.report_valid));
            compare_field("accessory_state", 4'(want.accessory_state),
                          4'(got.accessory_state));
            compare_field("polarity_mode", 4'(want.polarity_mode),
                          4'(got.polarity_mode));
            compare_field("detect_enable", 4'(want.detect_enable),
                          4'(got.detect_enable));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void flag_leftovers();
            if (expected_results.size() != 0) begin
                $error("%0d expected results never arrived", expected_results.size());
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;
    logic       i_valid;
    logic       o_stall;
    logic       i_action;
    logic       i_jack_present;
    logic       i_detect_valid;
    logic       i_detect_closed;
    logic [8:0] i_impedance_level;
    logic       o_valid;
    logic       i_stall;
    logic       o_event_handled;
    logic       o_report_valid;
    logic [1:0] o_accessory_state;
    logic [2:0] o_polarity_mode;
    logic       o_detect_enable;

    jack_event_scoreboard sb;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int sent_count = 0;

    headset_jack_detect_fsm_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_jack_present    (i_jack_present),
        .i_detect_valid    (i_detect_valid),
        .i_detect_closed   (i_detect_closed),
        .i_impedance_level (i_impedance_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_handled   (o_event_handled),
        .o_report_valid    (o_report_valid),
        .o_accessory_state (o_accessory_state),
        .o_polarity_mode   (o_polarity_mode),
        .o_detect_enable   (o_detect_enable)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Values read here are the ones present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_request({i_action, i_jack_present, i_detect_valid,
                             i_detect_closed, i_impedance_level});
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_event_handled, o_report_valid, o_accessory_state,
                             o_polarity_mode, o_detect_enable});
    end

    // Result side stall: random bursts, plus one long hold on request.
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_item random_item();
        logic [$bits(t_item)-1:0] raw;
        raw = ITEM_W'($urandom);
        return t_item'(raw);
    endfunction

    function automatic t_item jack_item(logic present);
        t_item it;
        it = random_item();
        it.action       = ACT_JACK;
        it.jack_present = present;
        return it;
    endfunction

    function automatic t_item mic_item(logic valid, logic closed, logic [8:0] imp);
        t_item it;
        it = random_item();
        it.action          = ACT_MIC;
        it.detect_valid    = valid;
        it.detect_closed   = closed;
        it.impedance_level = imp;
        return it;
    endfunction

    function automatic logic [8:0] mid_level();
        logic [8:0] imp;
        imp[8]   = 1'b0;
        imp[7:1] = 7'($urandom_range(1, 127));
        imp[0]   = 1'($urandom);
        return imp;
    endfunction

    task automatic send_item(t_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_action, i_jack_present, i_detect_valid, i_detect_closed, i_impedance_level} <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // Only written with the block drained.
    task automatic write_mode_count(logic [3:0] value);
        i_valid <= 1'b0;
        // let the monitor note a request taken at the last edge
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_mode_count(value);
    endtask

    // Insertion, a run of mid-level readings with some invalid ones, then at most one way of ending it.
    task automatic run_session();
        int flips;
        int k;
        flips = $urandom_range(0, 9);
        send_item(jack_item(1'b1));
        for (k = 0; k < flips; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(mic_item(1'b0, 1'($urandom), 9'($urandom)));
            send_item(mic_item(1'b1, 1'b1, mid_level()));
        end
        case ($urandom_range(0, 5))
            0: send_item(mic_item(1'b1, 1'b1, {1'b1, 8'($urandom)}));
            1: send_item(mic_item(1'b1, 1'b1, 9'h001));
            2: send_item(mic_item(1'b1, 1'b0, 9'($urandom)));
            3: send_item(mic_item(1'b1, 1'b1, 9'h000));
            4: send_item(jack_item(1'b0));
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            send_item(mic_item(1'b1, 1'b1, 9'($urandom_range(1, 255))));
    endtask

    initial begin
        logic [3:0] cfg_values [NUM_PHASES];
        t_item      odd_jack;
        int         phase;
        int         target;
        int         k;
        bit         hold_done;

        cfg_values = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4};
        sb = new();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_valid           <= 1'b0;
        i_action          <= 1'b0;
        i_jack_present    <= 1'b0;
        i_detect_valid    <= 1'b0;
        i_detect_closed   <= 1'b0;
        i_impedance_level <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, mode count at its reset value
        send_item(mic_item(1'b0, 1'b1, 9'h100));   // invalid reading
        send_item(mic_item(1'b1, 1'b1, 9'h002));   // mid straight out of reset
        send_item(mic_item(1'b1, 1'b1, 9'h080));   // last mode -> headphones
        send_item(mic_item(1'b1, 1'b1, 9'h001));   // short, not detecting
        send_item(jack_item(1'b1));
        send_item(mic_item(1'b1, 1'b1, 9'h000));
        send_item(mic_item(1'b1, 1'b1, 9'h001));   // short while detecting
        send_item(jack_item(1'b1));
        send_item(mic_item(1'b1, 1'b1, 9'h1FF));   // headset
        send_item(mic_item(1'b1, 1'b1, 9'h0FF));   // button with mic found
        send_item(jack_item(1'b1));
        send_item(mic_item(1'b1, 1'b0, 9'h1FF));   // open circuit beats impedance
        send_item(mic_item(1'b1, 1'b1, 9'h100));
        send_item(jack_item(1'b0));
        send_item(jack_item(1'b0));
        send_item(mic_item(1'b0, 1'b0, 9'h000));
        send_item(mic_item(1'b0, 1'b1, 9'h1FF));
        odd_jack = '1;
        odd_jack.action = ACT_JACK;
        send_item(odd_jack);
        send_item(mic_item(1'b1, 1'b1, 9'h0FE));
        send_item(mic_item(1'b1, 1'b1, 9'h0FE));
        send_item(mic_item(1'b1, 1'b1, 9'h1FE));
        send_item(jack_item(1'b1));
        send_item(mic_item(1'b1, 1'b1, 9'h101));   // high wins over short

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_mode_count(cfg_values[phase]);
            quiet     = (phase == NUM_PHASES - 1);
            target    = sent_count + PHASE_ITEMS;
            hold_done = 1'b0;
            while (sent_count < target) begin
                if ((phase == 1 || phase == 5) && !hold_done &&
                    sent_count >= target - PHASE_ITEMS / 2) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    send_item(random_item());
                else
                    run_session();
            end
        end
        i_valid <= 1'b0;

        for (k = 0; k < 1000 && sb.pending() != 0; k++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
